FILE: design/dfhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfhc_pkg
// Shared constants, types and helpers of the delimited field hash counter.
// ----------------------------------------------------------------------------
package dfhc_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned TAB_BITS      = $clog2(TABLE_ENTRIES);
  localparam int unsigned MAX_KEY_BYTES = 64;
  localparam int unsigned KEY_WORDS     = (MAX_KEY_BYTES + 7) / 8;
  localparam int unsigned KW_BITS       = $clog2(KEY_WORDS);
  localparam int unsigned LEN_BITS      = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned COUNT_BITS    = 32;
  localparam int unsigned OCC_BITS      = TAB_BITS + 1;
  localparam int unsigned KEY_ADDR_BITS = TAB_BITS + KW_BITS;

  localparam logic [63:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
  localparam logic [7:0]  PIPE_CHAR    = 8'h7C;
  localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;

  typedef enum logic {OP_BYTE = 1'b0, OP_READ = 1'b1} op_e;
  typedef enum logic {KIND_STATUS = 1'b0, KIND_READ = 1'b1} kind_e;
  typedef enum logic [1:0] {
    ST_COUNTED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_FULL     = 2'd3
  } stat_e;
  typedef enum logic [1:0] {
    PH_SEEK1 = 2'd0,
    PH_SEEK2 = 2'd1,
    PH_KEY   = 2'd2,
    PH_EOL   = 2'd3
  } phase_e;
  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_META, S_CMP, S_INS
  } ctl_state_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       chunk_start;
    logic [9:0] slot_index;
    logic [2:0] word_index;
  } dfhc_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  status;
    logic [9:0]  slot;
    logic        slot_valid;
    logic [31:0] hit_count;
    logic [6:0]  key_length;
    logic [63:0] key_word;
  } dfhc_out_t;

  typedef struct packed {
    logic                  used;
    logic [LEN_BITS-1:0]   len;
    logic [COUNT_BITS-1:0] count;
  } meta_t;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic rd_issue;
    logic rd_done;
    logic look_start;
    logic ovf_done;
    logic probe_next;
    logic cmp_start;
    logic cmp_step;
    logic hit_done;
    logic ins_start;
    logic full_done;
    logic ins_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic key_close;
    logic key_ovf;
    logic clr_last;
    logic meta_used;
    logic len_match;
    logic table_full;
    logic word_last;
    logic word_eq;
    logic mismatch;
    logic out_busy;
  } dp_stat_t;

  // FNV-1a step; the prime is 2^40 + 0x1B3, so the product is a sum of shifts
  function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

FILE: design/dfhc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfhc_in_if / dfhc_out_if
// Valid/ready channels carrying input requests and result items.
// ----------------------------------------------------------------------------
interface dfhc_in_if import dfhc_pkg::*;;
  logic     valid;
  logic     ready;
  dfhc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dfhc_out_if import dfhc_pkg::*;;
  logic      valid;
  logic      ready;
  dfhc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/dfhc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfhc_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module dfhc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: design/dfhc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfhc_dp
// Datapath: record parser, key buffer and hash, slot tables, output register.
// ----------------------------------------------------------------------------
module dfhc_dp import dfhc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctl_cmd_t  cmd_i,
  input  dfhc_in_t  in_data_i,
  input  logic      out_ready_i,
  output dp_stat_t  stat_o,
  output logic      out_valid_o,
  output dfhc_out_t out_data_o
);
  phase_e                 phase_q, phase_d, ph;
  logic [63:0]            hash_q, hash_d;
  logic [LEN_BITS-1:0]    fld_len_q, fld_len_d;
  logic                   ovf_q, ovf_d;
  logic [63:0]            fbuf_q [KEY_WORDS];
  logic [63:0]            fbuf_d [KEY_WORDS];
  logic [OCC_BITS-1:0]    occ_q, occ_d;
  logic [TAB_BITS-1:0]    clr_q, probe_q, probe_d;
  logic [KW_BITS-1:0]     cw_q, cw_d;
  logic                   mis_q, mis_d, word_ok_q;
  logic                   out_valid_q, out_valid_d;
  dfhc_out_t              out_q, out_d;
  logic                   is_pipe, parse, start_key;
  logic                   meta_we, key_we;
  logic [TAB_BITS-1:0]    meta_addr;
  logic [KEY_ADDR_BITS-1:0] key_addr;
  logic [$bits(meta_t)-1:0] meta_wdata, meta_rdata;
  logic [63:0]            key_wdata, key_rdata;
  meta_t                  meta_rd;
  logic [COUNT_BITS-1:0]  cnt_inc;

  assign meta_rd = meta_t'(meta_rdata);
  assign cnt_inc = (meta_rd.count == '1) ? meta_rd.count : meta_rd.count + 1'b1;
  assign is_pipe = in_data_i.data_byte == PIPE_CHAR;
  assign ph      = in_data_i.chunk_start ? PH_SEEK1 : phase_q;
  assign parse   = cmd_i.accept && (in_data_i.operation == OP_BYTE);
  assign start_key = in_data_i.chunk_start || (ph == PH_SEEK2 && is_pipe);

  assign stat_o.is_read    = in_data_i.operation == OP_READ;
  assign stat_o.key_close  = in_data_i.operation == OP_BYTE && ph == PH_KEY && is_pipe
                             && (fld_len_q != '0 || ovf_q);
  assign stat_o.key_ovf    = ovf_q;
  assign stat_o.clr_last   = clr_q == TAB_BITS'(TABLE_ENTRIES - 1);
  assign stat_o.meta_used  = meta_rd.used;
  assign stat_o.len_match  = meta_rd.len == fld_len_q;
  assign stat_o.table_full = occ_q >= OCC_BITS'(TABLE_ENTRIES / 2);
  assign stat_o.word_last  = cw_q == KW_BITS'(KEY_WORDS - 1);
  assign stat_o.word_eq    = key_rdata == fbuf_q[cw_q];
  assign stat_o.mismatch   = mis_q;
  assign stat_o.out_busy   = out_valid_q;

  always_comb begin
    phase_d   = phase_q;
    hash_d    = hash_q;
    fld_len_d = fld_len_q;
    ovf_d     = ovf_q;
    fbuf_d    = fbuf_q;
    if (parse) begin
      if (start_key) begin
        hash_d    = FNV_BASIS;
        fld_len_d = '0;
        ovf_d     = 1'b0;
        for (int i = 0; i < KEY_WORDS; i++) begin
          fbuf_d[i] = '0;
        end
      end
      unique case (ph)
        PH_SEEK1: if (is_pipe) phase_d = PH_SEEK2;
        PH_SEEK2: if (is_pipe) phase_d = PH_KEY;
        PH_KEY: begin
          if (is_pipe) begin
            phase_d = PH_EOL;
          end else begin
            if (fld_len_q < LEN_BITS'(MAX_KEY_BYTES)) begin
              fbuf_d[fld_len_q[KW_BITS+2:3]][fld_len_q[2:0]*8 +: 8] = in_data_i.data_byte;
              fld_len_d = fld_len_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
            hash_d = fnv_step(hash_q, in_data_i.data_byte);
          end
        end
        PH_EOL: if (in_data_i.data_byte == NEWLINE_CHAR) phase_d = PH_SEEK1;
        default: phase_d = PH_SEEK1;
      endcase
    end
  end

  always_comb begin
    meta_addr  = probe_q;
    meta_we    = 1'b0;
    meta_wdata = meta_rdata;
    key_addr   = {probe_q, cw_q};
    key_we     = cmd_i.ins_step;
    key_wdata  = fbuf_q[cw_q];
    probe_d    = probe_q;
    cw_d       = cw_q;
    mis_d      = mis_q;
    occ_d      = occ_q;
    if (cmd_i.clr_step) begin
      meta_addr  = clr_q;
      meta_we    = 1'b1;
      meta_wdata = '0;
    end
    if (cmd_i.rd_issue) begin
      meta_addr = in_data_i.slot_index;
      key_addr  = {in_data_i.slot_index, in_data_i.word_index};
      probe_d   = in_data_i.slot_index;
    end
    if (cmd_i.look_start) begin
      meta_addr = hash_q[TAB_BITS-1:0];
      probe_d   = hash_q[TAB_BITS-1:0];
    end
    if (cmd_i.probe_next) begin
      meta_addr = probe_q + 1'b1;
      probe_d   = probe_q + 1'b1;
    end
    if (cmd_i.cmp_start) begin
      key_addr = {probe_q, KW_BITS'(0)};
      cw_d     = '0;
      mis_d    = 1'b0;
    end
    if (cmd_i.cmp_step) begin
      key_addr = {probe_q, cw_q + 1'b1};
      cw_d     = cw_q + 1'b1;
      mis_d    = mis_q | ~stat_o.word_eq;
    end
    if (cmd_i.hit_done) begin
      meta_we    = 1'b1;
      meta_wdata = {1'b1, meta_rd.len, cnt_inc};
    end
    if (cmd_i.ins_start) begin
      meta_we    = 1'b1;
      meta_wdata = {1'b1, fld_len_q, COUNT_BITS'(1)};
      cw_d       = '0;
      occ_d      = occ_q + 1'b1;
    end
    if (cmd_i.ins_step) begin
      cw_d = cw_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = '0;
    out_d.result_kind = KIND_STATUS;
    out_d.slot        = probe_q;
    if (cmd_i.rd_done) begin
      out_d.result_kind = KIND_READ;
      out_d.slot_valid  = meta_rd.used;
      if (meta_rd.used) begin
        out_d.hit_count  = 32'(meta_rd.count);
        out_d.key_length = 7'(meta_rd.len);
        out_d.key_word   = word_ok_q ? key_rdata : '0;
      end
    end else if (cmd_i.hit_done) begin
      out_d.status     = ST_COUNTED;
      out_d.slot_valid = 1'b1;
      out_d.hit_count  = 32'(cnt_inc);
      out_d.key_length = 7'(meta_rd.len);
    end else if (cmd_i.ins_start) begin
      out_d.status     = ST_INSERTED;
      out_d.slot_valid = 1'b1;
      out_d.hit_count  = 32'd1;
      out_d.key_length = 7'(fld_len_q);
    end else if (cmd_i.ovf_done) begin
      out_d.status = ST_TOO_LONG;
      out_d.slot   = '0;
    end else begin
      out_d.status = ST_FULL;
      out_d.slot   = '0;
    end
    if (cmd_i.rd_done || cmd_i.hit_done || cmd_i.ins_start || cmd_i.ovf_done
        || cmd_i.full_done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SEEK1;
      hash_q      <= FNV_BASIS;
      fld_len_q   <= '0;
      ovf_q       <= 1'b0;
      occ_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hash_q      <= hash_d;
      fld_len_q   <= fld_len_d;
      ovf_q       <= ovf_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fbuf_q  <= fbuf_d;
    probe_q <= probe_d;
    cw_q    <= cw_d;
    mis_q   <= mis_d;
    if (cmd_i.rd_done || cmd_i.hit_done || cmd_i.ins_start || cmd_i.ovf_done
        || cmd_i.full_done) begin
      out_q <= out_d;
    end
    if (cmd_i.rd_issue) begin
      word_ok_q <= {1'b0, in_data_i.word_index} < 4'(KEY_WORDS);
    end
  end

  dfhc_ram #(.WIDTH($bits(meta_t)), .DEPTH(TABLE_ENTRIES)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .addr_i  (meta_addr),
    .wdata_i (meta_wdata),
    .rdata_o (meta_rdata)
  );

  dfhc_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES * KEY_WORDS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .addr_i  (key_addr),
    .wdata_i (key_wdata),
    .rdata_o (key_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_BITS'(TABLE_ENTRIES / 2))
    else $error("occupancy above half the table");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.hit_done || cmd_i.ins_start || cmd_i.full_done || cmd_i.rd_done)
    |-> !out_valid_q)
    else $error("result loaded over a pending result");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fld_len_q <= LEN_BITS'(MAX_KEY_BYTES))
    else $error("key length beyond limit");
  a_insert_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_start |=> occ_q == $past(occ_q) + 1'b1)
    else $error("insert did not advance occupancy");
endmodule

FILE: design/dfhc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfhc_ctrl
// Controller: table clear, slot reads, probe walk, key compare and insert.
// ----------------------------------------------------------------------------
module dfhc_ctrl import dfhc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output logic     in_ready_o,
  output ctl_cmd_t cmd_o
);
  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = !stat_i.out_busy || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          cmd_o.accept = 1'b1;
          if (stat_i.is_read) begin
            cmd_o.rd_issue = 1'b1;
            state_d = S_READ;
          end else if (stat_i.key_close) begin
            if (stat_i.key_ovf) begin
              cmd_o.ovf_done = 1'b1;
            end else begin
              cmd_o.look_start = 1'b1;
              state_d = S_META;
            end
          end
        end
      end
      S_READ: begin
        cmd_o.rd_done = 1'b1;
        state_d = S_IDLE;
      end
      S_META: begin
        if (!stat_i.meta_used) begin
          if (stat_i.table_full) begin
            cmd_o.full_done = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.ins_start = 1'b1;
            state_d = S_INS;
          end
        end else if (stat_i.len_match) begin
          cmd_o.cmp_start = 1'b1;
          state_d = S_CMP;
        end else begin
          cmd_o.probe_next = 1'b1;
        end
      end
      S_CMP: begin
        if (!stat_i.word_last) begin
          cmd_o.cmp_step = 1'b1;
        end else if (!stat_i.mismatch && stat_i.word_eq) begin
          cmd_o.hit_done = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d = S_META;
        end
      end
      S_INS: begin
        cmd_o.ins_step = 1'b1;
        if (stat_i.word_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o)
    else $error("request taken during table clear");
  a_read_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_issue |=> cmd_o.rd_done)
    else $error("slot read result not produced");
endmodule

FILE: design/delimited_field_hash_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_field_hash_counter
// Counts third-field keys of pipe-delimited records in an FNV-1a hash table.
//
//   channel  dir  payload
//   in_i     in   operation, data_byte, chunk_start, slot_index, word_index
//   out_o    out  result_kind, status, slot, slot_valid, hit_count,
//                 key_length, key_word
//
// A stream byte is taken in S_IDLE; a slot read then passes through S_READ.
// A closing pipe after a key that fits walks the slot RAM from the hash slot,
// compares all eight key words when the stored length matches, or inserts.
// After reset a clearing pass sweeps all 1024 slot RAM entries; no request
// is taken until it ends. A pending result holds while out_o is stalled.
// ----------------------------------------------------------------------------
module delimited_field_hash_counter import dfhc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dfhc_in_if.sink     in_i,
  dfhc_out_if.source  out_o
);
  ctl_cmd_t cmd;
  dp_stat_t stat;

  dfhc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd)
  );

  dfhc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .stat_o      (stat),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );
endmodule

FILE: test/dfhc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfhc_checker
// Watches the request and result channels of the hash counter, keeps its own
// model of the parser and hash table, and compares every result in order.
// ----------------------------------------------------------------------------
module dfhc_checker import dfhc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  dfhc_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  dfhc_out_t   out_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  phase_e                phase;
  logic [63:0]           hash;
  int unsigned           key_len;
  bit                    key_ovf;
  logic [63:0]           key_buf [KEY_WORDS];
  logic [63:0]           store_words [TABLE_ENTRIES][KEY_WORDS];
  int unsigned           store_len [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] store_count [TABLE_ENTRIES];
  bit                    store_used [TABLE_ENTRIES];
  int unsigned           occupied;
  dfhc_out_t             expected_results [$];

  assign pending_o = expected_results.size();

  function automatic logic [63:0] fnv_mix(logic [63:0] h, logic [7:0] b);
    return (h ^ {56'd0, b}) * 64'd1099511628211;
  endfunction

  function automatic void clear_key();
    hash    = FNV_BASIS;
    key_len = 0;
    key_ovf = 0;
    foreach (key_buf[w]) key_buf[w] = '0;
  endfunction

  function automatic bit key_equal(int unsigned s);
    if (store_len[s] != key_len) return 0;
    for (int w = 0; w < KEY_WORDS; w++)
      if (store_words[s][w] != key_buf[w]) return 0;
    return 1;
  endfunction

  function automatic dfhc_out_t close_key();
    dfhc_out_t   r;
    int unsigned s;
    r = '0;
    r.result_kind = KIND_STATUS;
    s = 32'(hash % TABLE_ENTRIES);
    if (key_ovf) begin
      r.status = ST_TOO_LONG;
      return r;
    end
    for (int p = 0; p < TABLE_ENTRIES && store_used[s]; p++) begin
      if (key_equal(s)) begin
        if (store_count[s] != COUNT_MAX) store_count[s]++;
        r.status = ST_COUNTED;
        r.slot = 10'(s);
        r.slot_valid = 1;
        r.hit_count = store_count[s];
        r.key_length = 7'(store_len[s]);
        return r;
      end
      s = (s + 1) % TABLE_ENTRIES;
    end
    if (occupied * 2 >= TABLE_ENTRIES || store_used[s]) begin
      r.status = ST_FULL;
      return r;
    end
    for (int w = 0; w < KEY_WORDS; w++) store_words[s][w] = key_buf[w];
    store_len[s] = key_len;
    store_count[s] = COUNT_BITS'(1);
    store_used[s] = 1;
    occupied++;
    r.status = ST_INSERTED;
    r.slot = 10'(s);
    r.slot_valid = 1;
    r.hit_count = 32'd1;
    r.key_length = 7'(key_len);
    return r;
  endfunction

  function automatic void apply_request(dfhc_in_t q);
    dfhc_out_t   r;
    int unsigned s;
    r = '0;
    if (q.operation == OP_READ) begin
      s = q.slot_index % TABLE_ENTRIES;
      r.result_kind = KIND_READ;
      r.slot = 10'(s);
      if (store_used[s]) begin
        r.slot_valid = 1;
        r.hit_count = store_count[s];
        r.key_length = 7'(store_len[s]);
        if (q.word_index < KEY_WORDS) r.key_word = store_words[s][q.word_index];
      end
      expected_results.push_back(r);
      return;
    end
    if (q.chunk_start) begin
      phase = PH_SEEK1;
      clear_key();
    end
    case (phase)
      PH_SEEK1: if (q.data_byte == PIPE_CHAR) phase = PH_SEEK2;
      PH_SEEK2: if (q.data_byte == PIPE_CHAR) begin
        phase = PH_KEY;
        clear_key();
      end
      PH_KEY: begin
        if (q.data_byte == PIPE_CHAR) begin
          phase = PH_EOL;
          if (key_len != 0 || key_ovf) expected_results.push_back(close_key());
        end else begin
          if (key_len < MAX_KEY_BYTES) begin
            key_buf[key_len / 8][(key_len % 8) * 8 +: 8] = q.data_byte;
            key_len++;
          end else begin
            key_ovf = 1;
          end
          hash = fnv_mix(hash, q.data_byte);
        end
      end
      default: if (q.data_byte == NEWLINE_CHAR) phase = PH_SEEK1;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    phase = PH_SEEK1;
    occupied = 0;
    clear_key();
    foreach (store_used[s]) store_used[s] = 0;
  end

  always @(posedge clk_i) begin
    dfhc_out_t e;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data_i.key_word, 64'd0);
        end else begin
          e = expected_results.pop_front();
          if (out_data_i.result_kind !== e.result_kind)
            report_mismatch("result_kind", 64'(out_data_i.result_kind), 64'(e.result_kind));
          if (out_data_i.status !== e.status)
            report_mismatch("status", 64'(out_data_i.status), 64'(e.status));
          if (out_data_i.slot !== e.slot)
            report_mismatch("slot", 64'(out_data_i.slot), 64'(e.slot));
          if (out_data_i.slot_valid !== e.slot_valid)
            report_mismatch("slot_valid", 64'(out_data_i.slot_valid), 64'(e.slot_valid));
          if (out_data_i.hit_count !== e.hit_count)
            report_mismatch("hit_count", 64'(out_data_i.hit_count), 64'(e.hit_count));
          if (out_data_i.key_length !== e.key_length)
            report_mismatch("key_length", 64'(out_data_i.key_length), 64'(e.key_length));
          if (out_data_i.key_word !== e.key_word)
            report_mismatch("key_word", out_data_i.key_word, e.key_word);
        end
      end
      if (in_valid_i && in_ready_i) apply_request(in_data_i);
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives records and slot reads into the hash counter with random idling on
// both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import dfhc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   calm;
  int   sent;

  dfhc_in_if  req_ch ();
  dfhc_out_if res_ch ();

  delimited_field_hash_counter u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch.sink),
    .out_o  (res_ch.source)
  );

  dfhc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_ch.valid),
    .in_ready_i   (req_ch.ready),
    .in_data_i    (req_ch.data),
    .out_valid_i  (res_ch.valid),
    .out_ready_i  (res_ch.ready),
    .out_data_i   (res_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 0;
  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(negedge clk_i) begin
    res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 28);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** delimited_field_hash_counter: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(dfhc_in_t q);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 28) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.data  <= q;
    req_ch.valid <= 1'b1;
    #1;
    while (!req_ch.ready) begin
      @(negedge clk_i);
      #1;
    end
    @(posedge clk_i);
    sent++;
  endtask

  task automatic rest();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
  endtask

  task automatic send_byte(logic [7:0] b, logic first = 0);
    dfhc_in_t q;
    q = '0;
    q.operation = OP_BYTE;
    q.data_byte = b;
    q.chunk_start = first;
    q.slot_index = 10'($urandom);
    q.word_index = 3'($urandom);
    send(q);
  endtask

  task automatic send_read(logic [9:0] s, logic [2:0] w);
    dfhc_in_t q;
    q = '0;
    q.operation = OP_READ;
    q.data_byte = 8'($urandom);
    q.chunk_start = 1'($urandom);
    q.slot_index = s;
    q.word_index = w;
    send(q);
  endtask

  task automatic send_record(string key, logic tail_junk);
    send_byte("a");
    send_byte(PIPE_CHAR);
    send_byte("b");
    send_byte(PIPE_CHAR);
    foreach (key[i]) send_byte(key[i]);
    send_byte(PIPE_CHAR);
    if (tail_junk) send_byte(PIPE_CHAR);
    send_byte(NEWLINE_CHAR);
  endtask

  function automatic string pool_key(int n, int len);
    string k;
    k = "";
    for (int i = 0; i < len; i++) k = {k, string'(8'(8'h41 + (n + i) % 26))};
    return k;
  endfunction

  initial begin
    string k;
    logic [7:0] b;
    int len;
    rst_ni = 0;
    calm = 0;
    sent = 0;
    idle_cycles = 0;
    req_ch.valid = 0;
    req_ch.data = '0;
    res_ch.ready = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    send_byte(PIPE_CHAR, 1);
    send_byte(PIPE_CHAR);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(NEWLINE_CHAR);
    send_byte(PIPE_CHAR);
    send_read(10'd1023, 3'd0);
    send_byte(PIPE_CHAR);
    send_byte(NEWLINE_CHAR);
    send_byte(PIPE_CHAR);
    send_byte(PIPE_CHAR);
    send_byte(PIPE_CHAR);
    send_byte(NEWLINE_CHAR);
    send_record(pool_key(0, 64), 1);
    send_record(pool_key(0, 64), 0);
    send_record(pool_key(3, 65), 0);
    send_record(pool_key(5, 1), 0);
    for (int s = 0; s < 8; s++) send_read(10'($urandom), 3'(s));

    rest();
    while (pending != 0) @(negedge clk_i);
    calm = 1;
    for (int i = 0; i < 20; i++) send_record(pool_key(i % 6, 1 + i % 9), 0);
    calm = 0;

    while (sent < 550) begin
      case ($urandom_range(9))
        0: send_byte(8'($urandom), $urandom_range(3) == 0);
        1, 2: begin
          send_read(10'($urandom), 3'($urandom));
        end
        default: begin
          len = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
          k = "";
          for (int i = 0; i < len; i++) begin
            b = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(8'h41 + $urandom_range(5));
            if (b == PIPE_CHAR) b = 8'h7D;
            k = {k, string'(b)};
          end
          send_record(k, $urandom_range(1));
        end
      endcase
    end

    rest();
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("** delimited_field_hash_counter: PASSED **");
    end else begin
      $display("** delimited_field_hash_counter: FAILED **");
    end
    $finish;
  end

endmodule
